// ----- design/jts_pkg.sv -----
// jts_pkg: shared types and codes of the json token scanner
// token record, scanner result bundle, token/role/error codes, character codes
// no dependencies
`timescale 1ns / 1ps

package jts_pkg;

    // token kinds
    localparam logic [3:0] KIND_LBRACE   = 4'd0;
    localparam logic [3:0] KIND_RBRACE   = 4'd1;
    localparam logic [3:0] KIND_LBRACKET = 4'd2;
    localparam logic [3:0] KIND_RBRACKET = 4'd3;
    localparam logic [3:0] KIND_COLON    = 4'd4;
    localparam logic [3:0] KIND_COMMA    = 4'd5;
    localparam logic [3:0] KIND_STRING   = 4'd6;
    localparam logic [3:0] KIND_NUMBER   = 4'd7;
    localparam logic [3:0] KIND_TRUE     = 4'd8;
    localparam logic [3:0] KIND_FALSE    = 4'd9;
    localparam logic [3:0] KIND_NULL     = 4'd10;
    localparam logic [3:0] KIND_ERROR    = 4'd11;

    // token roles
    localparam logic [1:0] ROLE_NONE  = 2'd0;
    localparam logic [1:0] ROLE_KEY   = 2'd1;
    localparam logic [1:0] ROLE_VALUE = 2'd2;

    // error kinds
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NO_QUOTE  = 2'd1;
    localparam logic [1:0] ERR_LITERAL   = 2'd2;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

    // character codes
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;

    // literal words packed, first byte highest
    localparam logic [39:0] LIT_TRUE  = 40'h00_7472_7565;
    localparam logic [39:0] LIT_FALSE = 40'h66_616C_7365;
    localparam logic [39:0] LIT_NULL  = 40'h00_6E75_6C6C;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  role;
        logic [1:0]  err;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic        last;
    } t_token;

    // up to two tokens per input byte, in order
    typedef struct packed {
        logic [1:0] count;
        t_token     first;
        t_token     second;
    } t_scan_out;

endpackage

// ----- design/jts_scan.sv -----
// jts_scan: byte-serial lexer state and per-byte token decode
// one byte per cycle, up to two tokens out; uses jts_pkg
`timescale 1ns / 1ps

module jts_scan
    import jts_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output t_scan_out  o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRING,
        S_AFTER_STRING,
        S_NUMBER,
        S_LITERAL
    } t_mode;

    localparam int EW = (CW > 16) ? CW : 16;

    t_mode          r_mode, n_mode;
    logic [CW-1:0]  r_line, n_line;
    logic [CW-1:0]  r_col, n_col;
    logic [CW-1:0]  r_start, n_start;
    logic [CW-1:0]  r_len, n_len;
    logic [39:0]    r_prefix, n_prefix;

    logic           pre_valid, idle_valid, run_idle;
    t_token         pre_tok, idle_tok, lit_tok;
    logic [1:0]     role_sel;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + CW'(1);
    endfunction

    function automatic logic [15:0] clamp16(input logic [CW-1:0] v);
        logic [EW-1:0] e;
        e = EW'(v);
        return (e > EW'(32'h0000_FFFF)) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic t_token mk(input logic [3:0] kind, input logic [1:0] role,
                                  input logic [1:0] err, input logic [CW-1:0] col,
                                  input logic [CW-1:0] len, input logic [CW-1:0] line);
        t_token t;
        t.kind = kind;
        t.role = role;
        t.err  = err;
        t.line = clamp16(line);
        t.col  = clamp16(col);
        t.len  = clamp16(len);
        t.last = 1'b0;
        return t;
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return c == CH_COMMA || c == CH_RBRACE || c == CH_COLON || c == CH_SPACE ||
               c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    // literal check against the three keywords
    always_comb begin
        if (r_len == CW'(4) && r_prefix == LIT_TRUE) begin
            lit_tok = mk(KIND_TRUE, ROLE_NONE, ERR_NONE, r_start, CW'(4), r_line);
        end else if (r_len == CW'(5) && r_prefix == LIT_FALSE) begin
            lit_tok = mk(KIND_FALSE, ROLE_NONE, ERR_NONE, r_start, CW'(5), r_line);
        end else if (r_len == CW'(4) && r_prefix == LIT_NULL) begin
            lit_tok = mk(KIND_NULL, ROLE_NONE, ERR_NONE, r_start, CW'(4), r_line);
        end else begin
            lit_tok = mk(KIND_ERROR, ROLE_NONE, ERR_LITERAL, r_col, r_len, r_line);
        end
    end

    assign role_sel = (i_byte == CH_COLON) ? ROLE_KEY : ROLE_VALUE;

    always_comb begin
        n_mode     = r_mode;
        n_line     = r_line;
        n_col      = r_col;
        n_start    = r_start;
        n_len      = r_len;
        n_prefix   = r_prefix;
        pre_valid  = 1'b0;
        pre_tok    = lit_tok;
        idle_valid = 1'b0;
        idle_tok   = mk(KIND_ERROR, ROLE_NONE, ERR_UNEXPECTED, r_col, CW'(1), r_line);
        run_idle   = 1'b0;

        if (i_eos) begin
            // flush whatever token is still open
            unique case (r_mode)
                S_STRING: begin
                    pre_valid = 1'b1;
                    pre_tok   = mk(KIND_ERROR, ROLE_NONE, ERR_NO_QUOTE, r_col, r_len, r_line);
                end
                S_AFTER_STRING: begin
                    pre_valid = 1'b1;
                    pre_tok   = mk(KIND_STRING, ROLE_VALUE, ERR_NONE, r_start, r_len, r_line);
                end
                S_NUMBER: begin
                    pre_valid = 1'b1;
                    pre_tok   = mk(KIND_NUMBER, ROLE_VALUE, ERR_NONE, r_start, r_len, r_line);
                end
                S_LITERAL: begin
                    pre_valid = 1'b1;
                    pre_tok   = lit_tok;
                end
                default: begin
                end
            endcase
            n_mode = S_IDLE;
        end else begin
            unique case (r_mode)
                S_STRING: begin
                    if (i_byte == CH_QUOTE) begin
                        n_col  = sat_inc(r_col);
                        n_mode = S_AFTER_STRING;
                    end else if (i_byte == CH_COLON) begin
                        pre_valid = 1'b1;
                        pre_tok   = mk(KIND_ERROR, ROLE_NONE, ERR_NO_QUOTE, r_col, r_len,
                                       r_line);
                        run_idle  = 1'b1;
                    end else begin
                        n_len = sat_inc(r_len);
                        n_col = sat_inc(r_col);
                    end
                end
                S_AFTER_STRING: begin
                    pre_valid = 1'b1;
                    pre_tok   = mk(KIND_STRING, role_sel, ERR_NONE, r_start, r_len, r_line);
                    run_idle  = 1'b1;
                end
                S_NUMBER, S_LITERAL: begin
                    if (is_term(i_byte)) begin
                        pre_valid = 1'b1;
                        if (r_mode == S_NUMBER) begin
                            pre_tok = mk(KIND_NUMBER, role_sel, ERR_NONE, r_start, r_len,
                                         r_line);
                        end else begin
                            pre_tok = lit_tok;
                        end
                        run_idle = 1'b1;
                    end else begin
                        if (r_mode == S_LITERAL && r_len < CW'(5)) begin
                            n_prefix = {r_prefix[31:0], i_byte};
                        end
                        n_len = sat_inc(r_len);
                        n_col = sat_inc(r_col);
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase

            // idle scan of the current byte, from the present counters
            if (run_idle) begin
                n_mode = S_IDLE;
                unique case (i_byte)
                    CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COLON, CH_COMMA: begin
                        idle_valid = 1'b1;
                        n_col      = sat_inc(r_col);
                        case (i_byte)
                            CH_LBRACE:   idle_tok.kind = KIND_LBRACE;
                            CH_RBRACE:   idle_tok.kind = KIND_RBRACE;
                            CH_LBRACKET: idle_tok.kind = KIND_LBRACKET;
                            CH_RBRACKET: idle_tok.kind = KIND_RBRACKET;
                            CH_COLON:    idle_tok.kind = KIND_COLON;
                            default:     idle_tok.kind = KIND_COMMA;
                        endcase
                        idle_tok.err = ERR_NONE;
                    end
                    CH_QUOTE: begin
                        n_start = r_col;
                        n_len   = '0;
                        n_col   = sat_inc(r_col);
                        n_mode  = S_STRING;
                    end
                    CH_LF: begin
                        n_line = sat_inc(r_line);
                        n_col  = CW'(1);
                    end
                    CH_SPACE, CH_TAB: begin
                        n_col = sat_inc(r_col);
                    end
                    CH_T, CH_F, CH_N: begin
                        n_start  = r_col;
                        n_len    = CW'(1);
                        n_prefix = {32'd0, i_byte};
                        n_col    = sat_inc(r_col);
                        n_mode   = S_LITERAL;
                    end
                    default: begin
                        n_col = sat_inc(r_col);
                        if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
                            n_start = r_col;
                            n_len   = CW'(1);
                            n_mode  = S_NUMBER;
                        end else begin
                            idle_valid = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // order the tokens and mark the final one
    always_comb begin
        o_res.count  = i_valid ? (2'(pre_valid) + 2'(idle_valid)) : 2'd0;
        o_res.first  = pre_valid ? pre_tok : idle_tok;
        o_res.first.last = !(pre_valid && idle_valid);
        o_res.second = idle_tok;
        o_res.second.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= S_IDLE;
            r_line   <= CW'(1);
            r_col    <= CW'(1);
            r_start  <= CW'(1);
            r_len    <= '0;
            r_prefix <= '0;
        end else if (i_valid) begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_col    <= n_col;
            r_start  <= n_start;
            r_len    <= n_len;
            r_prefix <= n_prefix;
        end
    end

endmodule

// ----- design/jts_outq.sv -----
// jts_outq: three-entry shift queue holding finished tokens for the output side
// takes up to two tokens per cycle, gives one; uses jts_pkg
`timescale 1ns / 1ps

module jts_outq
    import jts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_out i_push,
    input  logic      i_pop,
    output logic      o_valid,
    output t_token    o_head,
    output logic      o_room
);

    logic [1:0] r_cnt, n_cnt;
    t_token     r_q [3];
    t_token     n_q [3];
    t_token     sh  [3];
    logic       pop;
    logic [1:0] base;

    assign pop     = i_pop && (r_cnt != 2'd0);
    assign base    = r_cnt - 2'(pop);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[0];
    // room for two tokens whatever the output side does
    assign o_room  = (r_cnt <= 2'd1);

    always_comb begin
        sh[0] = pop ? r_q[1] : r_q[0];
        sh[1] = pop ? r_q[2] : r_q[1];
        sh[2] = r_q[2];
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < base) begin
                n_q[i] = sh[i];
            end else if (2'(i) == base) begin
                n_q[i] = i_push.first;
            end else begin
                n_q[i] = i_push.second;
            end
        end
        n_cnt = base + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

// ----- design/json_token_scanner.sv -----
// a token enters the output queue at the byte transfer that caused it
// throughput: one byte per cycle while o_s_axis_tready is high; a byte that closes a token
//   and starts another gives two tokens, and o_s_axis_tready is low while two or more are
//   queued; the queue drains one token per cycle if i_m_axis_tready is high, setting that rate
// reset (i_rst_n low, synchronous): scanner idle, line and column 1, queue empty
`timescale 1ns / 1ps

module json_token_scanner
    import jts_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] end_of_stream
    // token stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] token_role, [3:2] error_kind, [19:4] line_number,
    // [35:20] column_number, [51:36] token_length, [55:52] zero
    output logic [55:0] o_m_axis_tdata,
    output logic [3:0]  o_m_axis_tuser,   // [3:0] token_kind
    output logic        o_m_axis_tlast    // last token caused by one byte transfer
);

    logic      in_xfer;
    t_scan_out scan_res;
    t_token    head;

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // lexer: state registers plus the per-byte decode
    jts_scan #(
        .CW (COUNTER_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_xfer),
        .i_byte  (i_s_axis_tdata),
        .i_eos   (i_s_axis_tuser[0]),
        .o_res   (scan_res)
    );

    // result registers, decoupling the two sides
    jts_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (scan_res),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_head  (head),
        .o_room  (o_s_axis_tready)
    );

    // pack the token onto the master side
    assign o_m_axis_tdata = {4'd0, head.len, head.col, head.line, head.err, head.role};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule

// ----- design/jts_checker.sv -----
// jts_checker: port-level checks on the json token scanner outputs
// bound to json_token_scanner; uses jts_pkg
`timescale 1ns / 1ps

module jts_checker
    import jts_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata,
    input logic [3:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // error code present exactly on error tokens
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tuser == KIND_ERROR) == (o_m_axis_tdata[3:2] != ERR_NONE)))
        else $error("error kind does not match token kind");

    // role set exactly on strings and numbers
    a_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[1:0] != ROLE_NONE) ==
            (o_m_axis_tuser == KIND_STRING || o_m_axis_tuser == KIND_NUMBER)))
        else $error("token role does not match token kind");

    // line and column count from one
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[19:4] != 16'd0 && o_m_axis_tdata[35:20] != 16'd0))
        else $error("zero line or column");

    // stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) &&
             $stable(o_m_axis_tlast)))
        else $error("stalled token changed");

endmodule

bind json_token_scanner jts_checker u_jts_checker (.*);
